>>> hw/rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg: shared types for the sorted list insert block
// Default depth, control state encoding and the control bundle that goes
// to the cells.
// ----------------------------------------------------------------------------
package sli_pkg;

	localparam int unsigned SLI_DEPTH = 16;
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned POS_W     = 4;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} sli_state_t;

	// control bundle from the sequencer to the cell row
	typedef struct packed {
		logic insert;   // insert new value this cycle
		logic rotate;   // shift row toward cell 0, wrap at tail
		logic dropped;  // store was full on the current run
	} sli_ctl_t;

endpackage

>>> hw/rtl/sli_cell.sv
// ----------------------------------------------------------------------------
// sli_cell: one entry of the sorted row
// Holds one value; on insert it keeps, takes the new value or takes its
// left neighbor; on rotate it takes the value handed in from the right.
// ----------------------------------------------------------------------------
module sli_cell
	import sli_pkg::*;
(
	input  logic                     clk,
	input  sli_ctl_t                 ctl,
	input  logic signed [VAL_W-1:0]  new_value,
	input  logic signed [VAL_W-1:0]  left_value,
	input  logic                     left_gt,
	input  logic                     occupied,
	input  logic                     is_slot,
	input  logic signed [VAL_W-1:0]  rot_value,
	output logic signed [VAL_W-1:0]  value_q,
	output logic                     gt
);

	// greater than the new value: this cell and all to its right move up
	assign gt = occupied && (value_q > new_value);

	always_ff @(posedge clk) begin
		if (ctl.insert && (gt || is_slot)) begin
			value_q <= left_gt ? left_value : new_value;
		end else if (ctl.rotate) begin
			value_q <= rot_value;
		end
	end

endmodule

>>> hw/rtl/sli_ctrl.sv
// ----------------------------------------------------------------------------
// sli_ctrl: sequencer for the sorted list insert block
// Tracks entry count and output position, runs idle / emit states.
// ----------------------------------------------------------------------------
module sli_ctrl
	import sli_pkg::*;
#(
	parameter int unsigned DEPTH = SLI_DEPTH,
	localparam int unsigned CW = $clog2(DEPTH + 1),
	localparam int unsigned PW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output sli_ctl_t      ctl,
	output logic [CW-1:0] count_q,
	output logic [PW-1:0] pos_q,
	output logic          last
);

	sli_state_t state_q, state_d;
	logic       full;
	logic       in_fire;
	logic       out_fire;
	logic       dropped_q;

	assign full     = (count_q == CW'(DEPTH));
	assign last     = (CW'(pos_q) == count_q - CW'(1));
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready && last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		ctl.insert  = 1'b0;
		ctl.rotate  = 1'b0;
		ctl.dropped = dropped_q;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				ctl.insert = in_valid && !full;
			end
			ST_EMIT: begin
				out_valid  = 1'b1;
				ctl.rotate = out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			pos_q     <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				dropped_q <= full;
				pos_q     <= '0;
				if (!full) count_q <= count_q + CW'(1);
			end else if (out_fire) begin
				pos_q <= last ? '0 : pos_q + PW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/sorted_list_insert.sv
// ----------------------------------------------------------------------------
// sorted_list_insert: ascending sorted store with full dump per insert
// Row of DEPTH cells kept in ascending signed order; each insert is
// followed by a dump of the whole store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready, new_value): one beat per value.
//   The value is inserted after any equal entries: every cell compares
//   against new_value at once and either keeps its value, takes its left
//   neighbor or takes the new value.
//   Output channel (out_valid / out_ready): after each insert the store is
//   dumped smallest first, one beat per entry, entry_position counting from
//   zero (low four bits), last_entry on the final beat. The dump rotates
//   the cell row toward cell 0 with wraparound at the tail, so after
//   count beats the row is back in order.
//   Full store: the new value is discarded, and every beat of the dump
//   carries was_dropped.
//   Sequence: one accept in the idle state, then count beats (1..DEPTH);
//   in_ready is low for the whole dump.
//   Stall: out_ready low holds the row and the beat on the port.
//   Reset: arst_n clears the count and the sequencer; cell contents are
//   not reset and are never shown before being written.
// ----------------------------------------------------------------------------
module sorted_list_insert
	import sli_pkg::*;
#(
	parameter int unsigned DEPTH = SLI_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [VAL_W-1:0]  new_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [VAL_W-1:0]  entry_value,
	output logic [POS_W-1:0]         entry_position,
	output logic                     last_entry,
	output logic                     was_dropped
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = $clog2(DEPTH);

	sli_ctl_t              ctl;
	logic [CW-1:0]         count_q;
	logic [PW-1:0]         pos_q;
	logic                  last;
	logic signed [VAL_W-1:0] cell_value [DEPTH];
	logic                  cell_gt    [DEPTH];

	sli_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ctl      (ctl),
		.count_q  (count_q),
		.pos_q    (pos_q),
		.last     (last)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_value;
		logic                    left_gt;
		logic signed [VAL_W-1:0] rot_value;
		logic                    occupied;
		logic                    is_slot;
		logic                    is_tail;

		assign occupied = (CW'(i) < count_q);
		assign is_slot  = (CW'(i) == count_q);
		assign is_tail  = (CW'(i) == count_q - CW'(1));

		if (i == 0) begin : g_head
			assign left_value = '0;
			assign left_gt    = 1'b0;
		end else begin : g_body
			assign left_value = cell_value[i-1];
			assign left_gt    = cell_gt[i-1];
		end

		// rotate toward cell 0; the tail of the occupied run takes cell 0
		if (i == DEPTH - 1) begin : g_end
			assign rot_value = is_tail ? cell_value[0] : cell_value[i];
		end else begin : g_mid
			assign rot_value = is_tail ? cell_value[0] : cell_value[i+1];
		end

		sli_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_value (new_value),
			.left_value(left_value),
			.left_gt   (left_gt),
			.occupied  (occupied),
			.is_slot   (is_slot),
			.rot_value (rot_value),
			.value_q   (cell_value[i]),
			.gt        (cell_gt[i])
		);
	end

	// beat comes straight from cell 0 and the sequencer registers
	assign entry_value    = cell_value[0];
	assign entry_position = POS_W'(pos_q);
	assign last_entry     = last;
	assign was_dropped    = ctl.dropped;

endmodule

>>> hw/rtl/sli_chk.sv
// ----------------------------------------------------------------------------
// sli_chk: port checker for sorted_list_insert
// Watches the top level ports for run framing and ordering of beats.
// ----------------------------------------------------------------------------
module sli_chk
	import sli_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [VAL_W-1:0]  entry_value,
	input logic [POS_W-1:0]         entry_position,
	input logic                     last_entry,
	input logic                     was_dropped
);

	// a run starts at position zero right after an accepted beat
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid && entry_position == '0)
		else $error("run does not start at position zero");

	// no new input while a dump is in progress
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready during dump");

	// positions count up by one inside a run, drop flag stays put
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_entry |=>
			out_valid && entry_position == $past(entry_position) + 4'd1
			&& $stable(was_dropped))
		else $error("position or drop flag broke within a run");

	// the run ends after the last beat
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_entry |=> !out_valid)
		else $error("beat after last entry");

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_value))
		else $error("stalled beat changed");

endmodule

bind sorted_list_insert sli_chk u_sli_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.entry_value   (entry_value),
	.entry_position(entry_position),
	.last_entry    (last_entry),
	.was_dropped   (was_dropped)
);

>>> dv/sorted_list_insert_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_checker: scoreboard for the sorted list insert block
// Watches both channels. Each accepted input beat is run through a shadow
// sorted store to build the dump it should cause; each accepted output beat
// is compared field by field with the oldest queued dump beat.
// ----------------------------------------------------------------------------
module sorted_list_insert_checker
	import sli_pkg::*;
#(
	parameter int unsigned DEPTH = SLI_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic signed [VAL_W-1:0] new_value,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic signed [VAL_W-1:0] entry_value,
	input  logic [POS_W-1:0]        entry_position,
	input  logic                    last_entry,
	input  logic                    was_dropped,
	output int                      mismatch_count,
	output int                      pending_beats,
	output int                      insert_count,
	output int                      drop_count,
	output int                      beat_count
);

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
		logic                    last;
		logic                    dropped;
	} dump_beat_t;

	logic signed [VAL_W-1:0] shadow_store[$];
	dump_beat_t              dump_queue[$];

	// insert after equal entries, then queue the full dump
	task automatic insert_and_dump(input logic signed [VAL_W-1:0] value);
		int         slot;
		int         i;
		logic       full;
		dump_beat_t beat;
		full = (shadow_store.size() >= DEPTH);
		if (full) begin
			drop_count++;
		end else begin
			slot = 0;
			while (slot < shadow_store.size() && shadow_store[slot] <= value)
				slot++;
			shadow_store.insert(slot, value);
			insert_count++;
		end
		for (i = 0; i < shadow_store.size(); i++) begin
			beat.value    = shadow_store[i];
			beat.position = POS_W'(i);
			beat.last     = (i == shadow_store.size() - 1);
			beat.dropped  = full;
			dump_queue.push_back(beat);
		end
	endtask

	task automatic compare_dump_beat();
		dump_beat_t want;
		beat_count++;
		if (dump_queue.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t unexpected beat: value %0d pos %0d last %0b dropped %0b",
					$realtime, entry_value, entry_position, last_entry, was_dropped);
		end else begin
			want = dump_queue.pop_front();
			if (entry_value !== want.value || entry_position !== want.position ||
					last_entry !== want.last || was_dropped !== want.dropped) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t mismatch: exp value %0d pos %0d last %0b dropped %0b, got value %0d pos %0d last %0b dropped %0b",
						$realtime, want.value, want.position, want.last, want.dropped,
						entry_value, entry_position, last_entry, was_dropped);
			end
		end
	endtask

	// output side first, so a beat at the same edge as an accept never
	// matches the dump that accept is about to queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_store.delete();
			dump_queue.delete();
		end else begin
			if (out_valid && out_ready)
				compare_dump_beat();
			if (in_valid && in_ready)
				insert_and_dump(new_value);
		end
		pending_beats = dump_queue.size();
	end

endmodule

>>> dv/sorted_list_insert_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_test: top level bench for the sorted list insert block
// Fills the store with edge values and duplicates, then keeps offering
// random values to the full store so every dump flags the drop. Both
// channels idle at random; a long output hold-off backs up the input.
// ----------------------------------------------------------------------------
module sorted_list_insert_test;
	import sli_pkg::*;

	localparam int RANDOM_ITEMS    = 480;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int IDLE_PCT        = 20;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [VAL_W-1:0] new_value;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [VAL_W-1:0] entry_value;
	logic [POS_W-1:0]        entry_position;
	logic                    last_entry;
	logic                    was_dropped;

	int mismatch_count;
	int pending_beats;
	int insert_count;
	int drop_count;
	int beat_count;

	// idle enables, cleared for the quiet stretch in the middle of the run
	bit sender_idles   = 1'b1;
	bit receiver_idles = 1'b1;
	// set by the stimulus, cleared by the receiver once its hold-off ends
	bit hold_off_req   = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sorted_list_insert uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.new_value     (new_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.entry_value   (entry_value),
		.entry_position(entry_position),
		.last_entry    (last_entry),
		.was_dropped   (was_dropped)
	);

	sorted_list_insert_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.new_value     (new_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.entry_value   (entry_value),
		.entry_position(entry_position),
		.last_entry    (last_entry),
		.was_dropped   (was_dropped),
		.mismatch_count(mismatch_count),
		.pending_beats (pending_beats),
		.insert_count  (insert_count),
		.drop_count    (drop_count),
		.beat_count    (beat_count)
	);

	// Offer one beat. Called right after a rising edge; returns at the edge
	// where the beat was taken, so the next call drives in the same step
	// without a second assignment to in_valid.
	task automatic offer_value(input logic signed [VAL_W-1:0] value);
		while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		new_value <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// mix of uniform values, a narrow band around zero (duplicates) and
	// values near the two extremes
	function automatic logic signed [VAL_W-1:0] pick_value();
		logic signed [VAL_W-1:0] v;
		case ($urandom_range(3))
			0, 1: v = $urandom;
			2:    v = $signed($urandom_range(16)) - 8;
			default: begin
				if ($urandom_range(1))
					v = 32'sh7FFF_FFFF - $signed($urandom_range(3));
				else
					v = 32'sh8000_0000 + $signed($urandom_range(3));
			end
		endcase
		return v;
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			out_ready <= !(receiver_idles && $urandom_range(99) < IDLE_PCT);
		end
	end

	// stimulus and verdict
	initial begin
		logic signed [VAL_W-1:0] directed_values[$];
		int k;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		new_value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store first insert, new head, new tail, middle, then
		// duplicates of zero and both extremes, alternating bit patterns;
		// the sixteenth fills the store and the last three are dropped
		directed_values = '{
			32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd1,
			32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFE,
			32'sh8000_0001, 32'sh5555_5555, 32'shAAAA_AAAA, -32'sd2,
			32'sd2, 32'sd0, 32'sd100,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0
		};
		foreach (directed_values[i])
			offer_value(directed_values[i]);

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			// quiet stretch with no idling on either side
			if (k == 150) begin
				sender_idles   = 1'b0;
				receiver_idles = 1'b0;
			end
			if (k == 250) begin
				sender_idles   = 1'b1;
				receiver_idles = 1'b1;
			end
			// long output hold-off while inputs keep coming and back up
			if (k == 60)
				hold_off_req = 1'b1;
			// sender drains everything before going on
			if (k == 350) begin
				in_valid <= 1'b0;
				@(posedge clk);
				wait (pending_beats == 0);
				@(posedge clk);
			end
			offer_value(pick_value());
		end
		in_valid <= 1'b0;

		@(posedge clk);
		wait (pending_beats == 0);
		repeat (2 * SLI_DEPTH + 4) @(posedge clk);

		$display("covered %0d inserts into the sorted store, %0d values dropped on a full one",
			insert_count, drop_count);
		$display("%0d dump beats compared, with random stalls and a %0d-cycle output hold-off",
			beat_count, HOLD_OFF_CYCLES);
		if (mismatch_count == 0 && pending_beats == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
